/* rtl/core/cht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the bounded-chain hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	// bucket index by reciprocal multiplication: quotient stage, then remainder stage
	localparam int MOD_STEPS = 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_CMP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mod_step;
		logic clr_step;
		logic fire;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_done;
		logic clr_last;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/cht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/cht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer: reset clearing pass, accept, bucket hash, row compare and
// write-back, output register handshake.
// ----------------------------------------------------------------------------
module cht_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output cht_pkg::dp_cmd_t        cmd,
	input  wire cht_pkg::dp_stat_t  stat
);

	cht_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			cht_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = cht_pkg::S_IDLE;
				end
			end
			cht_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = cht_pkg::S_HASH;
				end
			end
			cht_pkg::S_HASH: begin
				// the row read is issued while the index holds
				cmd.mod_step = !stat.mod_done;
				if (stat.mod_done) begin
					state_d = cht_pkg::S_CMP;
				end
			end
			cht_pkg::S_CMP: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.fire = 1'b1;
					state_d  = cht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cht_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/core/cht_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: bucket index unit, bucket row RAM, way compare and row update,
// result register.
// ----------------------------------------------------------------------------
module cht_dp #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cht_pkg::dp_cmd_t            cmd,
	output cht_pkg::dp_stat_t                stat,
	input  wire logic [1:0]                  in_command,
	input  wire logic [cht_pkg::KEY_W-1:0]   in_key,
	input  wire logic [cht_pkg::VAL_W-1:0]   in_value,
	output logic                             out_found,
	output logic      [cht_pkg::VAL_W-1:0]   out_value,
	output logic      [1:0]                  out_status
);

	localparam int BW     = $clog2(BUCKETS);
	localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W  = WAYS * cht_pkg::SLOT_W;
	localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	typedef cht_pkg::slot_t [WAYS-1:0] row_t;

	cht_pkg::cmd_t             cmd_q;
	logic [cht_pkg::KEY_W-1:0] key_q;
	logic [cht_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0]             bucket;
	logic [BW-1:0]             clr_q;

	logic                      ram_we;
	logic [BW-1:0]             ram_waddr;
	logic [ROW_W-1:0]          ram_wdata;
	logic [ROW_W-1:0]          ram_rdata;

	row_t                      row, new_row;
	logic                      hit, free, row_we;
	logic [WW-1:0]             hit_idx, free_idx;
	logic                      res_found;
	logic [cht_pkg::VAL_W-1:0] res_value;
	cht_pkg::status_t          res_status;

	logic                      found_q;
	logic [cht_pkg::VAL_W-1:0] value_q;
	logic [1:0]                status_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cht_pkg::cmd_t'(in_command);
			key_q <= in_key;
			val_q <= in_value;
		end
	end

	// bucket index = key mod BUCKETS
	if (IS_POW2) begin : g_mask
		logic [BW-1:0] bkt_q;

		always_ff @(posedge clk) begin
			if (cmd.load) begin
				bkt_q <= in_key[BW-1:0];
			end
		end

		assign bucket        = bkt_q;
		assign stat.mod_done = 1'b1;
	end else begin : g_recip
		// key / BUCKETS = (key * RECIP) >> SHIFT, exact over the whole key range
		localparam int SHIFT = cht_pkg::KEY_W + BW;
		localparam logic [cht_pkg::KEY_W:0] RECIP =
			(cht_pkg::KEY_W + 1)'(((64'd1 << SHIFT) / 64'(BUCKETS)) + 64'd1);

		logic [2*cht_pkg::KEY_W:0]     prod;
		logic [BW-1:0]                 quo_q;
		logic [BW-1:0]                 rem_q;
		logic [cht_pkg::MOD_CNT_W-1:0] cnt_q;

		assign prod = (2*cht_pkg::KEY_W + 1)'(key_q) * (2*cht_pkg::KEY_W + 1)'(RECIP);

		// the remainder is below 2**BW, so only the low BW bits of each term count
		always_ff @(posedge clk) begin
			if (cmd.mod_step) begin
				quo_q <= prod[SHIFT +: BW];
				rem_q <= key_q[BW-1:0] - quo_q * BW'(BUCKETS);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= '0;
			end else if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.mod_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end

		assign bucket        = rem_q;
		assign stat.mod_done = (cnt_q == cht_pkg::MOD_CNT_W'(cht_pkg::MOD_STEPS));
	end

	// clearing pass over every row after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clr_last = (clr_q == BW'(BUCKETS - 1));

	assign ram_we    = cmd.clr_step | (cmd.fire & row_we);
	assign ram_waddr = cmd.clr_step ? clr_q : bucket;
	assign ram_wdata = cmd.clr_step ? '0 : ROW_W'(new_row);

	cht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (bucket),
		.rdata (ram_rdata)
	);

	assign row = row_t'(ram_rdata);

	// lowest matching way and lowest free way
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].key == key_q) begin
				hit     = 1'b1;
				hit_idx = WW'(w);
			end
			if (!row[w].valid) begin
				free     = 1'b1;
				free_idx = WW'(w);
			end
		end
	end

	always_comb begin
		new_row    = row;
		row_we     = 1'b0;
		res_found  = hit;
		res_value  = '0;
		res_status = cht_pkg::STAT_DONE;
		unique case (cmd_q)
			cht_pkg::CMD_INSERT: begin
				if (hit) begin
					new_row[hit_idx].value = val_q;
					row_we                 = 1'b1;
				end else if (free) begin
					new_row[free_idx].valid = 1'b1;
					new_row[free_idx].key   = key_q;
					new_row[free_idx].value = val_q;
					row_we                  = 1'b1;
				end else begin
					res_status = cht_pkg::STAT_FULL;
				end
			end
			cht_pkg::CMD_REMOVE: begin
				if (hit) begin
					new_row[hit_idx].valid = 1'b0;
					row_we                 = 1'b1;
				end else begin
					res_status = cht_pkg::STAT_MISSING;
				end
			end
			cht_pkg::CMD_SEARCH: begin
				if (hit) begin
					res_value = row[hit_idx].value;
				end else begin
					res_status = cht_pkg::STAT_MISSING;
				end
			end
			default: begin
				// unused code: no operation
				res_found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			found_q  <= res_found;
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign out_found  = found_q;
	assign out_value  = value_q;
	assign out_status = status_q;

endmodule
`default_nettype wire

/* rtl/core/chained_hash_table.sv */
`timescale 1ns / 1ps
// Result path: the row at the bucket index is read in S_HASH, then S_CMP compares, writes back
// and registers the result beat; for BUCKETS not a power of two S_HASH first forms the index by
// reciprocal multiplication, a quotient step then a remainder step. Items go one at a time through
// the single bucket row RAM: one read, one compare, one write-back each; a stalled result beat
// holds the next. Reset: after arst_n rises, a clearing pass writes every row with s_tready low.
// A result beat waiting on m_tready does not stop the next item being accepted.
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-value table with bounded chains: key mod BUCKETS selects a row of WAYS
// slots; insert, remove and search run on one row per item.
// ----------------------------------------------------------------------------
module chained_hash_table #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value_in
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] value_out
	output logic      [2:0]  m_tuser    // [0] found, [2:1] status
);

	cht_pkg::dp_cmd_t  cmd;
	cht_pkg::dp_stat_t stat;
	logic              found;
	logic [1:0]        status;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cht_dp #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_tuser),
		.in_key     (s_tdata[31:0]),
		.in_value   (s_tdata[63:32]),
		.out_found  (found),
		.out_value  (m_tdata),
		.out_status (status)
	);

	assign m_tuser = {status, found};

endmodule
`default_nettype wire

/* rtl/core/cht_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module cht_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:1] != 2'd3)
		else $error("unused status code");

	// missing key or full bucket never reports a hit
	a_miss_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != 2'd0 |-> !m_tuser[0])
		else $error("found set with a failing status");

	// a nonzero value only comes from a hit
	a_value_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata != 32'd0 |-> m_tuser[0])
		else $error("value returned without a hit");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded-chain hash table. A short table of
// directed commands covers empty and full buckets, updates, removals, the
// unused command and extreme keys and values. A random run follows over a
// small pool of colliding keys. Each result beat is checked against its
// typed expectation or a shadow table, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

	localparam int BUCKETS = 16;
	localparam int WAYS    = 4;
	localparam int SLOTS   = BUCKETS * WAYS;
	localparam int RANDOM_ITEMS = 1200;
	localparam int POOL    = 32;
	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct {
		logic    found;
		logic    [31:0] value;
		cht_pkg::status_t status;
	} lookup_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [31:0] val;
		bit          typed;
		lookup_t     res;
	} stim_row_t;

	localparam int N_DIRECTED = 21;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	// shadow table
	bit          shadow_valid [SLOTS];
	logic [31:0] shadow_key   [SLOTS];
	logic [31:0] shadow_value [SLOTS];

	lookup_t     awaited_lookups [$];
	logic [31:0] key_pool [POOL];
	int          mismatches = 0;
	bit          steady     = 1'b0;

	// bucket 0 keys: 0, 16, 32, 48, 0xFFFFFFF0; bucket 15: 0xFFFFFFFF
	stim_row_t directed [N_DIRECTED] = '{
		'{cht_pkg::CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_MISSING}},
		'{cht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_MISSING}},
		'{CMD_NOP,             32'h1234_5678, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0010, 32'hA5A5_A5A5, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0020, 32'h5A5A_5A5A, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'hFFFF_FFF0, 32'h0000_0001, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0030, 32'h0000_0002, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_FULL}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0010, 32'hDEAD_BEEF, 1'b1,
			'{1'b1, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_SEARCH, 32'h0000_0010, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hDEAD_BEEF, cht_pkg::STAT_DONE}},
		'{CMD_NOP,             32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_REMOVE, 32'h0000_0020, 32'h0000_0000, 1'b1,
			'{1'b1, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_SEARCH, 32'h0000_0020, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_MISSING}},
		'{cht_pkg::CMD_INSERT, 32'h0000_0030, 32'h0000_0003, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_SEARCH, 32'h0000_0030, 32'h0000_0000, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_REMOVE, 32'h0000_0030, 32'h0000_0000, 1'b0,
			'{1'b0, 32'h0, cht_pkg::STAT_DONE}},
		'{cht_pkg::CMD_REMOVE, 32'h0000_0030, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0, cht_pkg::STAT_MISSING}},
		'{cht_pkg::CMD_SEARCH, 32'hFFFF_FFF0, 32'h0000_0000, 1'b1,
			'{1'b1, 32'h1, cht_pkg::STAT_DONE}}
	};

	chained_hash_table #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #6 clk = ~clk;

	// Apply one command to the shadow table and return what the block should report.
	function automatic lookup_t table_apply(logic [1:0] cmd, logic [31:0] key,
		logic [31:0] val);
		int base;
		int hit;
		int spare;
		lookup_t r;
		base  = int'(key % BUCKETS) * WAYS;
		hit   = -1;
		spare = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (hit < 0 && shadow_valid[base + w] && shadow_key[base + w] == key)
				hit = base + w;
			if (spare < 0 && !shadow_valid[base + w])
				spare = base + w;
		end
		r.found  = (hit >= 0);
		r.value  = '0;
		r.status = cht_pkg::STAT_DONE;
		case (cmd)
			cht_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					shadow_value[hit] = val;
				end else if (spare >= 0) begin
					shadow_valid[spare] = 1'b1;
					shadow_key[spare]   = key;
					shadow_value[spare] = val;
				end else begin
					r.status = cht_pkg::STAT_FULL;
				end
			end
			cht_pkg::CMD_REMOVE: begin
				if (hit >= 0)
					shadow_valid[hit] = 1'b0;
				else
					r.status = cht_pkg::STAT_MISSING;
			end
			cht_pkg::CMD_SEARCH: begin
				if (hit >= 0)
					r.value = shadow_value[hit];
				else
					r.status = cht_pkg::STAT_MISSING;
			end
			default: r.found = 1'b0;
		endcase
		return r;
	endfunction

	// Present one beat, hold it until taken, then record the expected lookup.
	task automatic send_command(logic [1:0] cmd, logic [31:0] key, logic [31:0] val,
		bit typed, lookup_t res);
		lookup_t predicted;
		while (!steady && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, key};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		predicted = table_apply(cmd, key, val);
		awaited_lookups.push_back(typed ? res : predicted);
	endtask

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return key_pool[$urandom_range(POOL - 1)];
		else if (r < 95)
			return $urandom;
		else
			return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
	endfunction

	function automatic logic [1:0] pick_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return cht_pkg::CMD_INSERT;
		else if (r < 65)
			return cht_pkg::CMD_REMOVE;
		else if (r < 95)
			return cht_pkg::CMD_SEARCH;
		else
			return CMD_NOP;
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
	endtask

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_lookups.size() == 0) begin
				flag_mismatch("unexpected beat", 32'h0, m_tdata);
			end else begin
				want = awaited_lookups.pop_front();
				if (m_tuser[0] !== want.found)
					flag_mismatch("found", 32'(want.found), 32'(m_tuser[0]));
				if (m_tdata !== want.value)
					flag_mismatch("value_out", want.value, m_tdata);
				if (m_tuser[2:1] !== want.status)
					flag_mismatch("status", 32'(want.status), 32'(m_tuser[2:1]));
			end
		end
	end

	initial begin
		lookup_t none;
		logic [31:0] k;
		int guard;
		none = '{1'b0, 32'h0, cht_pkg::STAT_DONE};
		for (int i = 0; i < POOL; i++) begin
			// crowd a few buckets so that hits, updates and full buckets are common
			k = $urandom;
			key_pool[i] = k - (k % BUCKETS) + $urandom_range(5);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_command(directed[i].cmd, directed[i].key, directed[i].val,
				directed[i].typed, directed[i].res);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 500 && i < 800);
			send_command(pick_cmd(), pick_key(), $urandom, 1'b0, none);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		guard = 0;
		while (awaited_lookups.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		// allow a stray late beat to show up
		repeat (16) @(posedge clk);
		if (mismatches == 0 && awaited_lookups.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/cht_pkg.sv
rtl/core/cht_ram.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dp.sv
rtl/core/chained_hash_table.sv
rtl/core/cht_checker.sv
bench/tb.sv
